// ===== hw/rtl/printer_text_line_breaker_unit_assert.svh =====
// Assertion macros for the printer text line breaker.
// Expects clk and arst_n in the scope of the including module.
`ifndef PRINTER_TEXT_LINE_BREAKER_UNIT_ASSERT_SVH
`define PRINTER_TEXT_LINE_BREAKER_UNIT_ASSERT_SVH

// same-cycle implication
`define PTLB_ASSERT_IMPLIES(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define PTLB_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/ptlb_pkg.sv =====
// Shared types and constants of the printer text line breaker.
// No dependencies; imported by every module of the block.
package ptlb_pkg;

	localparam int LINE_DOTS   = 384;
	localparam int DOTS_W      = $clog2(LINE_DOTS + 1);
	localparam int SUM_W       = (DOTS_W > 10) ? DOTS_W : 10;
	localparam int COL_W       = 9;
	localparam int BYTES_W     = 6;
	localparam int CODE_W      = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int ASC_DOTS  = 12;
	localparam int WIDE_DOTS = 24;
	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] BYTE_PAD   = 8'h80;
	localparam logic [7:0] BYTE_CR    = 8'h0d;
	localparam logic [7:0] BYTE_LF    = 8'h0a;
	localparam logic [7:0] BYTE_EOT   = 8'hff;
	localparam logic [7:0] TRAIL_LO   = 8'h40;
	localparam logic [7:0] TRAIL_HI   = 8'hfe;

	localparam logic EV_CHAR     = 1'b0;
	localparam logic EV_LINE_END = 1'b1;

	localparam logic CFG_LEFT_MARGIN  = 1'b0;
	localparam logic CFG_RIGHT_MARGIN = 1'b1;

	// one queued job: a placed character, a line end, or both in order
	typedef struct packed {
		logic                has_char;
		logic                has_end;
		logic                end_first;
		logic [CODE_W-1:0]   code;
		logic                wide;
		logic [COL_W-1:0]    col;
		logic [BYTES_W-1:0]  bytes;
	} job_t;

endpackage

// ===== hw/rtl/printer_text_line_breaker_unit.sv =====
// Printer text line breaker, top level.
// Depends on ptlb_pkg, ptlb_front, ptlb_queue, ptlb_back and the assertion header.
//
// Use: text bytes (ASCII or GBK lead/trail) enter on in_valid/in_ready/text_byte.
// Results leave on out_valid/out_ready with event_kind, char_code, is_wide,
// start_column, line_bytes and last_of_run; one byte gives zero, one or two
// results, the last of them flagged by last_of_run. Margins are written on the
// cfg_valid/cfg_ready/cfg_index/cfg_data channel (index 0 left, 1 right); write
// them only while no bytes are in flight. cfg_ready is always high.
// Path: the front classifies each byte and updates the budget, pushing a job into
// the queue; the back end registers each result in its output register.
// Throughput: one byte per cycle while the queue has room, one result per cycle
// while out_ready is high; a byte's two results leave the output register in turn.
// A four-entry job queue decouples the sides: when the receiver stalls, bytes
// keep coming in until the queue is full, then in_ready drops.
// Reset clears margins, the queue and the output; the budget starts at 384 dots.
module printer_text_line_breaker_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [ptlb_pkg::COL_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    text_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          event_kind,
	output logic [ptlb_pkg::CODE_W-1:0]   char_code,
	output logic                          is_wide,
	output logic [ptlb_pkg::COL_W-1:0]    start_column,
	output logic [ptlb_pkg::BYTES_W-1:0]  line_bytes,
	output logic                          last_of_run
);
	import ptlb_pkg::*;

	`include "printer_text_line_breaker_unit_assert.svh"

	logic q_full, q_push, q_empty, q_pop;
	job_t push_job, head_job;

	ptlb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.text_byte (text_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	ptlb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.head_job (head_job),
		.empty    (q_empty)
	);

	ptlb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_job        (head_job),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.char_code    (char_code),
		.is_wide      (is_wide),
		.start_column (start_column),
		.line_bytes   (line_bytes),
		.last_of_run  (last_of_run)
	);

	`PTLB_ASSERT_IMPLIES(a_end_clean, out_valid && event_kind == EV_LINE_END,
		char_code == '0 && !is_wide && start_column == '0, "line end carries char fields")
	`PTLB_ASSERT_IMPLIES(a_char_no_bytes, out_valid && event_kind == EV_CHAR,
		line_bytes == '0, "placed character carries a byte count")
	`PTLB_ASSERT_IMPLIES(a_wide_code, out_valid && is_wide,
		char_code[15:8] >= 8'h81 && char_code[7:0] >= TRAIL_LO, "malformed wide code")
	`PTLB_ASSERT_NEXT(a_pair_follows, out_valid && out_ready && !last_of_run,
		out_valid, "second result of a byte not presented")

endmodule

// ===== hw/rtl/ptlb_front.sv =====
// Front end: configuration registers, byte classification and dot budget.
// Depends on ptlb_pkg; pushes one job per result-producing byte.
module ptlb_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [ptlb_pkg::COL_W-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             text_byte,
	input  logic                   q_full,
	output logic                   q_push,
	output ptlb_pkg::job_t         q_job
);
	import ptlb_pkg::*;

	logic [COL_W-1:0]   left_margin_q, right_margin_q;
	logic [DOTS_W-1:0]  dots_left_q, dots_left_n;
	logic [BYTES_W-1:0] pending_q, pending_n;
	logic               lead_q, lead_n;
	logic [7:0]         held_q, held_n;

	logic               accept;
	logic [SUM_W-1:0]   msum;
	logic [DOTS_W-1:0]  budget, cost, dl_sub, diff, budget_less;
	logic               fits, do_place, wide;
	logic [CODE_W-1:0]  code;
	logic [COL_W-1:0]   col_calc;
	logic [BYTES_W-1:0] nb;
	logic [BYTES_W:0]   pend_sum;
	logic [BYTES_W-1:0] pend_inc;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;

	assign msum   = SUM_W'(left_margin_q) + SUM_W'(right_margin_q);
	assign budget = (msum >= SUM_W'(LINE_DOTS)) ? '0 : DOTS_W'(SUM_W'(LINE_DOTS) - msum);

	assign wide     = lead_q;
	assign code     = lead_q ? {held_q, text_byte} : {8'h00, text_byte};
	assign cost     = wide ? DOTS_W'(WIDE_DOTS) : DOTS_W'(ASC_DOTS);
	assign fits     = dots_left_q >= cost;
	assign dl_sub   = dots_left_q - cost;
	assign diff     = (budget >= dots_left_q) ? budget - dots_left_q : '0;
	assign col_calc = left_margin_q + COL_W'(diff);
	assign budget_less = (budget >= cost) ? budget - cost : '0;
	assign nb       = wide ? BYTES_W'(2) : BYTES_W'(1);
	assign pend_sum = {1'b0, pending_q} + {1'b0, nb};
	assign pend_inc = pend_sum[BYTES_W] ? BYTES_MAX : pend_sum[BYTES_W-1:0];

	always_comb begin
		dots_left_n = dots_left_q;
		pending_n   = pending_q;
		lead_n      = lead_q;
		held_n      = held_q;
		do_place    = 1'b0;
		q_push      = 1'b0;
		q_job       = '0;
		if (accept) begin
			if (lead_q) begin
				lead_n = 1'b0;
				do_place = (text_byte >= TRAIL_LO) && (text_byte <= TRAIL_HI);
			end else if (text_byte == BYTE_NUL || text_byte == BYTE_PAD) begin
				// filler byte, dropped
			end else if (text_byte == BYTE_CR || text_byte == BYTE_LF
					|| text_byte == BYTE_EOT) begin
				if (pending_q != '0) begin
					q_push        = 1'b1;
					q_job.has_end = 1'b1;
					q_job.bytes   = pending_q;
				end
				dots_left_n = budget;
				pending_n   = '0;
			end else if (!text_byte[7]) begin
				do_place = 1'b1;
			end else begin
				lead_n = 1'b1;
				held_n = text_byte;
			end
		end
		if (do_place) begin
			q_push         = 1'b1;
			q_job.has_char = 1'b1;
			q_job.code     = code;
			q_job.wide     = wide;
			if (fits) begin
				q_job.col = col_calc;
				if (dl_sub < DOTS_W'(ASC_DOTS)) begin
					// line full after this character
					q_job.has_end = 1'b1;
					q_job.bytes   = pend_inc;
					pending_n     = '0;
					dots_left_n   = budget;
				end else begin
					pending_n   = pend_inc;
					dots_left_n = dl_sub;
				end
			end else begin
				// overflow: flush first, character opens the next line
				q_job.has_end   = 1'b1;
				q_job.end_first = 1'b1;
				q_job.bytes     = pending_q;
				q_job.col       = left_margin_q;
				pending_n       = nb;
				dots_left_n     = budget_less;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_margin_q  <= '0;
			right_margin_q <= '0;
			dots_left_q    <= DOTS_W'(LINE_DOTS);
			pending_q      <= '0;
			lead_q         <= 1'b0;
			held_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LEFT_MARGIN:  left_margin_q  <= cfg_data;
					CFG_RIGHT_MARGIN: right_margin_q <= cfg_data;
					default: ;
				endcase
			end
			dots_left_q <= dots_left_n;
			pending_q   <= pending_n;
			lead_q      <= lead_n;
			held_q      <= held_n;
		end
	end

endmodule

// ===== hw/rtl/ptlb_queue.sv =====
// Short job queue between front and back end.
// Depends on ptlb_pkg for job_t and depth.
module ptlb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptlb_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output ptlb_pkg::job_t head_job,
	output logic           empty
);
	import ptlb_pkg::*;

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full     = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign head_job = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/ptlb_back.sv =====
// Back end: splits queued jobs into result transfers through an output register.
// Depends on ptlb_pkg.
module ptlb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  ptlb_pkg::job_t                q_job,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          event_kind,
	output logic [ptlb_pkg::CODE_W-1:0]   char_code,
	output logic                          is_wide,
	output logic [ptlb_pkg::COL_W-1:0]    start_column,
	output logic [ptlb_pkg::BYTES_W-1:0]  line_bytes,
	output logic                          last_of_run
);
	import ptlb_pkg::*;

	logic                valid_q, phase_q, last_q, kind_q, wide_q;
	logic [CODE_W-1:0]   code_q;
	logic [COL_W-1:0]    col_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic                load, two, emit_end, final_res;

	assign load      = !valid_q || out_ready;
	assign two       = q_job.has_char && q_job.has_end;
	// second half of a pair is the opposite of the first
	assign emit_end  = two ? (phase_q ^ q_job.end_first) : q_job.has_end;
	assign final_res = !two || phase_q;
	assign q_pop     = load && !q_empty && final_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (!q_empty) begin
				phase_q <= !final_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			last_q <= final_res;
			if (emit_end) begin
				kind_q  <= EV_LINE_END;
				code_q  <= '0;
				wide_q  <= 1'b0;
				col_q   <= '0;
				bytes_q <= q_job.bytes;
			end else begin
				kind_q  <= EV_CHAR;
				code_q  <= q_job.code;
				wide_q  <= q_job.wide;
				col_q   <= q_job.col;
				bytes_q <= '0;
			end
		end
	end

	assign out_valid    = valid_q;
	assign event_kind   = kind_q;
	assign char_code    = code_q;
	assign is_wide      = wide_q;
	assign start_column = col_q;
	assign line_bytes   = bytes_q;
	assign last_of_run  = last_q;

endmodule
